/* src/req_ack_link_master_assert.svh */
// Assertion macros shared by the link master checker.
// Needs i_clk and i_rst_n in the scope that uses them.
`ifndef REQ_ACK_LINK_MASTER_ASSERT_SVH
`define REQ_ACK_LINK_MASTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RLM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("link master check failed");

// Next-cycle implication, checked outside reset.
`define RLM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("link master check failed");

`endif

/* src/rlm_pkg.sv */
// Types and constants for the REQ/ACK link master.
// No dependencies; used by the top level and its checker.
package rlm_pkg;

    localparam int unsigned COUNT_W = 13;
    localparam int unsigned TICK_W  = 8;
    localparam int unsigned BYTE_W  = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX      = 13'd8191;
    localparam logic [TICK_W-1:0]  TICK_MAX       = 8'd255;
    localparam logic [COUNT_W-1:0] MAX_LEN_RESET  = 13'd128;
    localparam logic [TICK_W-1:0]  ACK_WAIT_RESET = 8'd5;

    // Configuration register indexes
    localparam logic CFG_MAX_MSG_LEN    = 1'b0;
    localparam logic CFG_ACK_WAIT_TICKS = 1'b1;

    typedef enum logic [1:0] {
        RT_TICK  = 2'd0,
        RT_READ  = 2'd1,
        RT_WRITE = 2'd2,
        RT_XFER  = 2'd3
    } t_req_type;

    typedef enum logic [3:0] {
        ST_NONE   = 4'd0,
        ST_GRANT  = 4'd1,
        ST_DENY   = 4'd2,
        ST_NODATA = 4'd3,
        ST_BUSY   = 4'd4,
        ST_ABORT  = 4'd5,
        ST_RDONE  = 4'd6,
        ST_WDONE  = 4'd7,
        ST_IDLE   = 4'd8
    } t_status;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_ACQ   = 5'b00010,
        PH_READ  = 5'b00100,
        PH_WRITE = 5'b01000,
        PH_REL   = 5'b10000
    } t_phase;

endpackage

/* src/req_ack_link_master.sv */
// REQ/ACK/MODE link master: request, ACK wait, byte transfer and release.
// The result is registered; a beat accepted at an edge shows its result from that edge on.
// Throughput: one beat per cycle; the input is taken while the result register
// is empty or being drained in the same cycle.
// Reset (i_rst_n low, synchronous): phase idle, REQ low, counters zero,
// max_msg_len 128, ack_wait_ticks 5. Uses rlm_pkg.
module req_ack_link_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic        i_ack_line,
    input  logic        i_ind_line,
    input  logic [7:0]  i_tx_byte,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_last_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_status,
    output logic        o_req_out,
    output logic        o_mode_out,
    output logic        o_port_enable,
    output logic [7:0]  o_port_byte,
    output logic        o_port_byte_valid,
    output logic [12:0] o_byte_count
);

    // configuration registers
    logic [rlm_pkg::COUNT_W-1:0] r_max_len;
    logic [rlm_pkg::TICK_W-1:0]  r_ack_wait;

    // link state
    rlm_pkg::t_phase             r_phase, n_phase;
    logic [rlm_pkg::TICK_W-1:0]  r_wait, n_wait;
    logic [rlm_pkg::COUNT_W-1:0] r_moved, n_moved;
    logic                        r_mode, n_mode;
    logic                        r_req, n_req;

    // result register
    logic                        r_out_valid;
    rlm_pkg::t_status            r_status, n_status;
    logic                        r_port_en, n_port_en;
    logic [rlm_pkg::BYTE_W-1:0]  r_pbyte, n_pbyte;
    logic                        r_pvalid, n_pvalid;

    logic                        accept;
    logic                        is_req;
    logic                        is_xfer;
    logic [rlm_pkg::TICK_W-1:0]  wait_inc;
    logic [rlm_pkg::COUNT_W-1:0] moved_inc;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign is_req  = (i_req_type == rlm_pkg::RT_READ) || (i_req_type == rlm_pkg::RT_WRITE);
    assign is_xfer = (i_req_type == rlm_pkg::RT_XFER);

    // saturating tick and byte counters
    assign wait_inc  = (r_wait == rlm_pkg::TICK_MAX) ? r_wait : r_wait + 8'd1;
    assign moved_inc = (r_moved == rlm_pkg::COUNT_MAX) ? r_moved : r_moved + 13'd1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len  <= rlm_pkg::MAX_LEN_RESET;
            r_ack_wait <= rlm_pkg::ACK_WAIT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                rlm_pkg::CFG_MAX_MSG_LEN:    r_max_len  <= i_cfg_data;
                rlm_pkg::CFG_ACK_WAIT_TICKS: r_ack_wait <= i_cfg_data[7:0];
                default:                     r_ack_wait <= r_ack_wait;
            endcase
        end
    end

    // next state and result for the beat on the input
    always_comb begin
        n_phase  = r_phase;
        n_wait   = r_wait;
        n_moved  = r_moved;
        n_mode   = r_mode;
        n_req    = r_req;
        n_status = rlm_pkg::ST_NONE;
        n_pbyte  = '0;
        n_pvalid = 1'b0;
        unique case (r_phase)
            rlm_pkg::PH_IDLE: begin
                if (is_req) begin
                    if (i_ack_line) begin
                        n_status = rlm_pkg::ST_BUSY;
                    end else if (i_req_type == rlm_pkg::RT_READ && !i_ind_line) begin
                        n_status = rlm_pkg::ST_NODATA;
                    end else begin
                        n_mode  = (i_req_type == rlm_pkg::RT_WRITE);
                        n_req   = 1'b1;
                        n_wait  = '0;
                        n_phase = rlm_pkg::PH_ACQ;
                    end
                end
            end
            rlm_pkg::PH_ACQ: begin
                n_wait = wait_inc;
                if (i_ack_line) begin
                    n_status = rlm_pkg::ST_GRANT;
                    n_moved  = '0;
                    n_phase  = r_mode ? rlm_pkg::PH_WRITE : rlm_pkg::PH_READ;
                end else if (wait_inc >= r_ack_wait) begin
                    n_status = rlm_pkg::ST_DENY;
                    n_req    = 1'b0;
                    n_phase  = rlm_pkg::PH_IDLE;
                end else if (is_req) begin
                    n_status = rlm_pkg::ST_BUSY;
                end
            end
            rlm_pkg::PH_READ: begin
                if (is_req) begin
                    n_status = rlm_pkg::ST_BUSY;
                end else if (!i_ack_line) begin
                    n_status = rlm_pkg::ST_RDONE;
                    n_req    = 1'b0;
                    n_phase  = rlm_pkg::PH_REL;
                end else if (is_xfer) begin
                    n_pbyte  = i_rx_byte;
                    n_pvalid = 1'b1;
                    n_moved  = moved_inc;
                    if (moved_inc >= r_max_len) begin
                        n_status = rlm_pkg::ST_RDONE;
                        n_req    = 1'b0;
                        n_phase  = rlm_pkg::PH_REL;
                    end
                end
            end
            rlm_pkg::PH_WRITE: begin
                if (is_req) begin
                    n_status = rlm_pkg::ST_BUSY;
                end else if (is_xfer) begin
                    n_pbyte  = i_tx_byte;
                    n_pvalid = 1'b1;
                    n_moved  = moved_inc;
                    if (!i_ack_line) begin
                        n_status = rlm_pkg::ST_ABORT;
                        n_req    = 1'b0;
                        n_phase  = rlm_pkg::PH_REL;
                    end else if (i_last_byte) begin
                        n_status = rlm_pkg::ST_WDONE;
                        n_req    = 1'b0;
                        n_phase  = rlm_pkg::PH_REL;
                    end
                end else if (!i_ack_line) begin
                    n_status = rlm_pkg::ST_ABORT;
                    n_req    = 1'b0;
                    n_phase  = rlm_pkg::PH_REL;
                end
            end
            rlm_pkg::PH_REL: begin
                if (!i_ack_line) begin
                    n_status = rlm_pkg::ST_IDLE;
                    n_phase  = rlm_pkg::PH_IDLE;
                end else if (is_req) begin
                    n_status = rlm_pkg::ST_BUSY;
                end
            end
            default: begin
                n_phase = rlm_pkg::PH_IDLE;
            end
        endcase
        n_port_en = (n_phase == rlm_pkg::PH_READ) || (n_phase == rlm_pkg::PH_WRITE);
    end

    // state update on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rlm_pkg::PH_IDLE;
            r_wait  <= '0;
            r_moved <= '0;
            r_mode  <= 1'b0;
            r_req   <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_wait  <= n_wait;
            r_moved <= n_moved;
            r_mode  <= n_mode;
            r_req   <= n_req;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_port_en <= n_port_en;
            r_pbyte   <= n_pbyte;
            r_pvalid  <= n_pvalid;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_req_out         = r_req;
    assign o_mode_out        = r_mode;
    assign o_port_enable     = r_port_en;
    assign o_port_byte       = r_pbyte;
    assign o_port_byte_valid = r_pvalid;
    assign o_byte_count      = r_moved;

endmodule

/* src/rlm_checker.sv */
// Port-level checks for the link master, bound to the top level.
// Uses rlm_pkg and the macros in req_ack_link_master_assert.svh.
`include "req_ack_link_master_assert.svh"

module rlm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  o_status,
    input logic        o_req_out,
    input logic        o_port_enable,
    input logic        o_port_byte_valid,
    input logic [12:0] o_byte_count
);

    logic granted;
    logic denied;
    logic ends_xfer;

    // decoded result status
    assign granted   = o_out_valid && (o_status == rlm_pkg::ST_GRANT);
    assign denied    = o_out_valid && (o_status == rlm_pkg::ST_DENY);
    assign ends_xfer = (o_status == rlm_pkg::ST_RDONE) || (o_status == rlm_pkg::ST_WDONE)
                    || (o_status == rlm_pkg::ST_ABORT);

    // an enabled port always has REQ up
    `RLM_ASSERT_NOW(a_port_needs_req, o_out_valid && o_port_enable, o_req_out)

    // a grant opens the port with a fresh count
    `RLM_ASSERT_NOW(a_grant_opens, granted, o_port_enable && o_byte_count == 13'd0)

    // denial leaves REQ down and the port closed
    `RLM_ASSERT_NOW(a_deny_drops, denied, !o_req_out && !o_port_enable)

    // a byte moves only in a transfer or on the beat that ends it
    `RLM_ASSERT_NOW(a_byte_in_xfer, o_out_valid && o_port_byte_valid, o_port_enable || ends_xfer)

    // a stalled result holds
    `RLM_ASSERT_NEXT(a_stall_holds, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status))

endmodule

bind req_ack_link_master rlm_checker u_rlm_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_status          (o_status),
    .o_req_out         (o_req_out),
    .o_port_enable     (o_port_enable),
    .o_port_byte_valid (o_port_byte_valid),
    .o_byte_count      (o_byte_count)
);

/* tb/sv/tb_top.sv */
// Self-checking testbench for req_ack_link_master: directed and state-guided random beats,
// randomly stalled on both channels, checked against an in-bench model of the link master.
// Depends on rlm_pkg and the req_ack_link_master RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // One input beat and one result beat, at the port widths
    typedef struct {
        rlm_pkg::t_req_type kind;
        logic               ack;
        logic               ind;
        logic [7:0]         tx;
        logic [7:0]         rx;
        logic               last;
    } t_link_step;

    typedef struct {
        rlm_pkg::t_status status;
        logic             req;
        logic             mode;
        logic             enable;
        logic [7:0]       pbyte;
        logic             pvalid;
        logic [12:0]      count;
    } t_link_result;

    // Register values plus the odds that steer the random beats of one run segment
    typedef struct {
        logic [12:0] max_len;
        logic [7:0]  ack_wait;
        int unsigned grant_odds;
        int unsigned drop_odds;
        int unsigned last_odds;
        int unsigned beats;
    } t_link_setting;

    // Tracks the link master state and checks results in order
    class link_tracker;
        rlm_pkg::t_phase phase;
        logic [7:0]      ticks;
        logic [12:0]     moved;
        logic            mode_lvl;
        logic            req_lvl;
        logic [12:0]     max_len;
        logic [7:0]      ack_wait;
        t_link_result    pending[$];
        int unsigned     faults;

        function new();
            phase    = rlm_pkg::PH_IDLE;
            ticks    = '0;
            moved    = '0;
            mode_lvl = 1'b0;
            req_lvl  = 1'b0;
            max_len  = rlm_pkg::MAX_LEN_RESET;
            ack_wait = rlm_pkg::ACK_WAIT_RESET;
            faults   = 0;
        endfunction

        function void set_register(logic idx, logic [12:0] value);
            if (idx == rlm_pkg::CFG_MAX_MSG_LEN) begin
                max_len = value;
            end else begin
                ack_wait = value[7:0];
            end
        endfunction

        // Drop REQ and wait for ACK low
        function void release_link();
            req_lvl = 1'b0;
            phase   = rlm_pkg::PH_REL;
        endfunction

        // Advance the state by one accepted beat and queue the result it causes
        function void take_request(t_link_step s);
            t_link_result r;
            logic         is_req;
            is_req   = (s.kind == rlm_pkg::RT_READ) || (s.kind == rlm_pkg::RT_WRITE);
            r.status = rlm_pkg::ST_NONE;
            r.pbyte  = '0;
            r.pvalid = 1'b0;
            case (phase)
                rlm_pkg::PH_IDLE: begin
                    if (is_req) begin
                        if (s.ack) begin
                            r.status = rlm_pkg::ST_BUSY;
                        end else if (s.kind == rlm_pkg::RT_READ && !s.ind) begin
                            r.status = rlm_pkg::ST_NODATA;
                        end else begin
                            mode_lvl = (s.kind == rlm_pkg::RT_WRITE);
                            req_lvl  = 1'b1;
                            ticks    = '0;
                            phase    = rlm_pkg::PH_ACQ;
                        end
                    end
                end
                rlm_pkg::PH_ACQ: begin
                    if (ticks != rlm_pkg::TICK_MAX) ticks = ticks + 8'd1;
                    if (s.ack) begin
                        r.status = rlm_pkg::ST_GRANT;
                        moved    = '0;
                        phase    = mode_lvl ? rlm_pkg::PH_WRITE : rlm_pkg::PH_READ;
                    end else if (ticks >= ack_wait) begin
                        r.status = rlm_pkg::ST_DENY;
                        req_lvl  = 1'b0;
                        phase    = rlm_pkg::PH_IDLE;
                    end else if (is_req) begin
                        r.status = rlm_pkg::ST_BUSY;
                    end
                end
                rlm_pkg::PH_READ: begin
                    if (is_req) begin
                        r.status = rlm_pkg::ST_BUSY;
                    end else if (!s.ack) begin
                        r.status = rlm_pkg::ST_RDONE;
                        release_link();
                    end else if (s.kind == rlm_pkg::RT_XFER) begin
                        r.pbyte  = s.rx;
                        r.pvalid = 1'b1;
                        if (moved != rlm_pkg::COUNT_MAX) moved = moved + 13'd1;
                        if (moved >= max_len) begin
                            r.status = rlm_pkg::ST_RDONE;
                            release_link();
                        end
                    end
                end
                rlm_pkg::PH_WRITE: begin
                    if (is_req) begin
                        r.status = rlm_pkg::ST_BUSY;
                    end else if (s.kind == rlm_pkg::RT_XFER) begin
                        r.pbyte  = s.tx;
                        r.pvalid = 1'b1;
                        if (moved != rlm_pkg::COUNT_MAX) moved = moved + 13'd1;
                        // ACK low after the byte aborts, even on the last one
                        if (!s.ack) begin
                            r.status = rlm_pkg::ST_ABORT;
                            release_link();
                        end else if (s.last) begin
                            r.status = rlm_pkg::ST_WDONE;
                            release_link();
                        end
                    end else if (!s.ack) begin
                        r.status = rlm_pkg::ST_ABORT;
                        release_link();
                    end
                end
                default: begin
                    if (!s.ack) begin
                        r.status = rlm_pkg::ST_IDLE;
                        phase    = rlm_pkg::PH_IDLE;
                    end else if (is_req) begin
                        r.status = rlm_pkg::ST_BUSY;
                    end
                end
            endcase
            r.req    = req_lvl;
            r.mode   = mode_lvl;
            r.enable = (phase == rlm_pkg::PH_READ) || (phase == rlm_pkg::PH_WRITE);
            r.count  = moved;
            pending.push_back(r);
        endfunction

        // Compare one result beat with the oldest expected one
        function void match_result(t_link_result got);
            t_link_result want;
            logic         bad;
            if (pending.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("%0t: result beat with none expected, status %0d count %0d",
                             $time, got.status, got.count);
                return;
            end
            want = pending.pop_front();
            bad = (got.status != want.status) || (got.req != want.req)
                || (got.mode != want.mode) || (got.enable != want.enable)
                || (got.pbyte != want.pbyte) || (got.pvalid != want.pvalid)
                || (got.count != want.count);
            if (bad) begin
                faults++;
                if (faults <= 10) begin
                    $display("%0t: mismatch exp st %0d req %0b mode %0b en %0b %02h/%0b cnt %0d",
                             $time, want.status, want.req, want.mode, want.enable,
                             want.pbyte, want.pvalid, want.count);
                    $display("%0t:          got st %0d req %0b mode %0b en %0b %02h/%0b cnt %0d",
                             $time, got.status, got.req, got.mode, got.enable,
                             got.pbyte, got.pvalid, got.count);
                end
            end
        endfunction
    endclass

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_cfg_wr_en       = 1'b0;
    logic        i_cfg_index       = 1'b0;
    logic [12:0] i_cfg_data        = '0;
    logic        i_in_valid        = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type        = '0;
    logic        i_ack_line        = 1'b0;
    logic        i_ind_line        = 1'b0;
    logic [7:0]  i_tx_byte         = '0;
    logic [7:0]  i_rx_byte         = '0;
    logic        i_last_byte       = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready       = 1'b0;
    logic [3:0]  o_status;
    logic        o_req_out;
    logic        o_mode_out;
    logic        o_port_enable;
    logic [7:0]  o_port_byte;
    logic        o_port_byte_valid;
    logic [12:0] o_byte_count;

    link_tracker tracker;
    bit          calm = 1'b0;

    // Register settings, extremes included; each runs a segment of random beats
    t_link_setting settings[6] = '{
        '{13'd128,  8'd5,   3, 12,  6, 200},
        '{13'd1,    8'd1,   2, 10,  4, 260},
        '{13'd4096, 8'd255, 6, 40, 30, 260},
        '{13'd0,    8'd0,   2,  8,  4, 260},
        '{13'd3,    8'd2,   3, 16,  8, 260},
        '{13'd17,   8'd9,   8, 20, 10, 300}
    };

    req_ack_link_master u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_req_type        (i_req_type),
        .i_ack_line        (i_ack_line),
        .i_ind_line        (i_ind_line),
        .i_tx_byte         (i_tx_byte),
        .i_rx_byte         (i_rx_byte),
        .i_last_byte       (i_last_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_req_out         (o_req_out),
        .o_mode_out        (o_mode_out),
        .o_port_enable     (o_port_enable),
        .o_port_byte       (o_port_byte),
        .o_port_byte_valid (o_port_byte_valid),
        .o_byte_count      (o_byte_count)
    );

    always #6 i_clk = ~i_clk;

    // Idle cycles before a beat: none in calm stretches, mostly short otherwise
    function automatic int unsigned pick_gap();
        if (calm) return 0;
        if ($urandom_range(0, 2) == 0) return $urandom_range(0, 19);
        return $urandom_range(0, 1);
    endfunction

    function automatic t_link_step mk(rlm_pkg::t_req_type kind, logic ack, logic ind,
                                      logic [7:0] tx, logic [7:0] rx, logic last);
        t_link_step s;
        s.kind = kind;
        s.ack  = ack;
        s.ind  = ind;
        s.tx   = tx;
        s.rx   = rx;
        s.last = last;
        return s;
    endfunction

    // Random beat, mostly shaped to carry the current transfer forward
    function automatic t_link_step shape_step(rlm_pkg::t_phase ph, t_link_setting k);
        t_link_step s;
        s.kind = rlm_pkg::t_req_type'(2'($urandom_range(0, 3)));
        s.ack  = 1'($urandom_range(0, 1));
        s.ind  = 1'($urandom_range(0, 1));
        s.tx   = 8'($urandom_range(0, 255));
        s.rx   = 8'($urandom_range(0, 255));
        s.last = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 7) != 0) begin
            case (ph)
                rlm_pkg::PH_IDLE: begin
                    s.kind = $urandom_range(0, 1) ? rlm_pkg::RT_READ : rlm_pkg::RT_WRITE;
                    s.ack  = ($urandom_range(0, 9) == 0);
                    s.ind  = ($urandom_range(0, 7) != 0);
                end
                rlm_pkg::PH_ACQ: begin
                    if ($urandom_range(0, 5) != 0)
                        s.kind = $urandom_range(0, 1) ? rlm_pkg::RT_TICK : rlm_pkg::RT_XFER;
                    s.ack = ($urandom_range(1, k.grant_odds) == 1);
                end
                rlm_pkg::PH_READ: begin
                    if ($urandom_range(0, 9) != 0) s.kind = rlm_pkg::RT_XFER;
                    s.ack = ($urandom_range(1, k.drop_odds) != 1);
                end
                rlm_pkg::PH_WRITE: begin
                    if ($urandom_range(0, 9) != 0) s.kind = rlm_pkg::RT_XFER;
                    s.ack  = ($urandom_range(1, k.drop_odds) != 1);
                    s.last = ($urandom_range(1, k.last_odds) == 1);
                end
                default: begin
                    if ($urandom_range(0, 3) != 0) s.kind = rlm_pkg::RT_TICK;
                end
            endcase
        end
        return s;
    endfunction

    // Present one input beat after a random gap; returns at the accepting edge
    task automatic send_step(input t_link_step s);
        int unsigned hold;
        hold = pick_gap();
        if (hold != 0) begin
            i_in_valid <= 1'b0;
            repeat (hold) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= s.kind;
        i_ack_line  <= s.ack;
        i_ind_line  <= s.ind;
        i_tx_byte   <= s.tx;
        i_rx_byte   <= s.rx;
        i_last_byte <= s.last;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.take_request(s);
    endtask

    // Stop sending and wait until every expected result beat is back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [12:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        tracker.set_register(idx, value);
        @(posedge i_clk);
    endtask

    // Stimulus: directed beats at reset settings, then one random segment per setting
    initial begin
        t_link_step plan[$];
        tracker = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        plan.push_back(mk(rlm_pkg::RT_TICK,  0, 0, 8'h00, 8'h00, 0)); // idle tick
        plan.push_back(mk(rlm_pkg::RT_READ,  1, 1, 8'h00, 8'h00, 0)); // ACK high: busy
        plan.push_back(mk(rlm_pkg::RT_READ,  0, 0, 8'h00, 8'h00, 0)); // no data
        plan.push_back(mk(rlm_pkg::RT_WRITE, 0, 0, 8'hFF, 8'hFF, 1)); // accepted
        plan.push_back(mk(rlm_pkg::RT_READ,  0, 1, 8'h00, 8'h00, 0)); // busy during ACK wait
        plan.push_back(mk(rlm_pkg::RT_TICK,  0, 0, 8'h00, 8'h00, 0));
        plan.push_back(mk(rlm_pkg::RT_TICK,  0, 0, 8'h00, 8'h00, 0));
        plan.push_back(mk(rlm_pkg::RT_TICK,  0, 0, 8'h00, 8'h00, 0));
        plan.push_back(mk(rlm_pkg::RT_XFER,  0, 0, 8'h00, 8'h00, 0)); // transfer as tick: denied
        plan.push_back(mk(rlm_pkg::RT_READ,  0, 1, 8'h00, 8'h00, 0));
        plan.push_back(mk(rlm_pkg::RT_XFER,  1, 1, 8'h00, 8'h00, 0)); // grant
        plan.push_back(mk(rlm_pkg::RT_XFER,  1, 0, 8'h00, 8'hFF, 0));
        plan.push_back(mk(rlm_pkg::RT_XFER,  1, 0, 8'hFF, 8'h00, 0));
        plan.push_back(mk(rlm_pkg::RT_WRITE, 1, 1, 8'h00, 8'h00, 0)); // busy in read
        plan.push_back(mk(rlm_pkg::RT_XFER,  0, 0, 8'h00, 8'hAA, 0)); // ACK low ends the read
        plan.push_back(mk(rlm_pkg::RT_READ,  1, 1, 8'h00, 8'h00, 0)); // busy in release
        plan.push_back(mk(rlm_pkg::RT_TICK,  0, 0, 8'h00, 8'h00, 0)); // idle again
        plan.push_back(mk(rlm_pkg::RT_WRITE, 0, 0, 8'h00, 8'h00, 0));
        plan.push_back(mk(rlm_pkg::RT_TICK,  1, 0, 8'h00, 8'h00, 0));
        plan.push_back(mk(rlm_pkg::RT_XFER,  1, 0, 8'hFF, 8'h00, 0));
        plan.push_back(mk(rlm_pkg::RT_TICK,  0, 0, 8'h00, 8'h00, 0)); // write tick, ACK low: abort
        plan.push_back(mk(rlm_pkg::RT_TICK,  0, 0, 8'h00, 8'h00, 0));
        plan.push_back(mk(rlm_pkg::RT_WRITE, 0, 1, 8'h00, 8'h00, 0));
        plan.push_back(mk(rlm_pkg::RT_TICK,  1, 0, 8'h00, 8'h00, 0));
        plan.push_back(mk(rlm_pkg::RT_XFER,  0, 0, 8'h00, 8'h00, 1)); // last byte, ACK low: abort
        plan.push_back(mk(rlm_pkg::RT_TICK,  0, 0, 8'h00, 8'h00, 0));
        plan.push_back(mk(rlm_pkg::RT_WRITE, 0, 0, 8'h00, 8'h00, 0));
        plan.push_back(mk(rlm_pkg::RT_TICK,  1, 0, 8'h00, 8'h00, 0));
        plan.push_back(mk(rlm_pkg::RT_XFER,  1, 0, 8'h5A, 8'h00, 1)); // write done
        plan.push_back(mk(rlm_pkg::RT_TICK,  0, 0, 8'h00, 8'h00, 0));
        foreach (plan[i]) send_step(plan[i]);
        settle();

        foreach (settings[p]) begin
            write_reg(rlm_pkg::CFG_MAX_MSG_LEN, settings[p].max_len);
            write_reg(rlm_pkg::CFG_ACK_WAIT_TICKS, {5'd0, settings[p].ack_wait});
            i_cfg_wr_en <= 1'b0;
            for (int n = 0; n < settings[p].beats; n++) begin
                if ($urandom_range(0, 39) == 0) calm = !calm;
                send_step(shape_step(tracker.phase, settings[p]));
            end
            settle();
        end

        if (tracker.faults == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Result side: random stalls, check every accepted result beat
    initial begin
        int unsigned  hold;
        t_link_result got;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            hold = pick_gap();
            if (hold != 0) begin
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got.status = rlm_pkg::t_status'(o_status);
            got.req    = o_req_out;
            got.mode   = o_mode_out;
            got.enable = o_port_enable;
            got.pbyte  = o_port_byte;
            got.pvalid = o_port_byte_valid;
            got.count  = o_byte_count;
            tracker.match_result(got);
        end
    end

    // Hang guard
    initial begin
        #(10_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/rlm_pkg.sv
src/req_ack_link_master.sv
src/rlm_checker.sv
tb/sv/tb_top.sv
